FILE: hdl/bdll_pkg.sv
// bdll_pkg: shared sizes, operation and status codes, and word types of the
// bounded doubly linked list. No dependencies; every other file uses it.
`default_nettype none

package bdll_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int OP_W       = 2;
	localparam int STAT_W     = 2;
	localparam int POS_W      = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_BACK  = 2'd1,
		OP_DELETE    = 2'd2,
		OP_SEARCH    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	// one entry of the list as held in a cell
	typedef struct packed {
		logic                  valid;
		logic [DATA_WIDTH-1:0] data;
	} cell_word_t;

	// control from the sequencer to the row of cells
	typedef struct packed {
		logic       shift;
		cell_word_t fill;
	} chain_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/bdll_cell.sv
// bdll_cell: one storage cell of the list ring, loads the word on its input on shift.
// Depends on bdll_pkg.
`default_nettype none

module bdll_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  shift,
	input  bdll_pkg::cell_word_t d,
	output bdll_pkg::cell_word_t q
);

	logic                            valid_q;
	logic [bdll_pkg::DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d.data;
		end
	end

	assign q.valid = valid_q;
	assign q.data  = data_q;

endmodule

`default_nettype wire

FILE: hdl/bdll_ctrl.sv
// bdll_ctrl: operation sequencer; steps the cell ring one full turn per word and
// rewrites the stream leaving the head cell. Depends on bdll_pkg.
`default_nettype none

module bdll_ctrl (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [bdll_pkg::OP_W-1:0]          op,
	input  wire  [bdll_pkg::DATA_WIDTH-1:0]    value,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [bdll_pkg::STAT_W-1:0]        status,
	output logic [bdll_pkg::POS_W-1:0]         position,
	input  bdll_pkg::cell_word_t               head_word,
	input  bdll_pkg::cell_word_t               next_word,
	output bdll_pkg::chain_ctl_t               chain_ctl
);

	bdll_pkg::state_t                state_q, state_d;
	logic [bdll_pkg::IDX_W-1:0]      step_q;
	bdll_pkg::op_t                   op_q;
	logic [bdll_pkg::DATA_WIDTH-1:0] key_q;
	logic [bdll_pkg::CNT_W-1:0]      count_q;
	logic                            flag_q, flag_d;
	bdll_pkg::cell_word_t            carry_q, carry_d;
	logic [bdll_pkg::POS_W-1:0]      pos_q, pos_d;
	logic                            out_valid_q;
	bdll_pkg::status_t               status_q, fin_status;
	logic [bdll_pkg::POS_W-1:0]      position_q, fin_pos;
	logic [bdll_pkg::CNT_W-1:0]      fin_count;

	logic                 accept, last, shift, finish, refused, match;
	bdll_pkg::cell_word_t fill;

	assign accept  = in_valid && !in_stall;
	assign last    = (step_q == bdll_pkg::IDX_W'(bdll_pkg::CAPACITY - 1));
	assign finish  = shift && last;
	assign refused = (count_q == bdll_pkg::CNT_W'(bdll_pkg::CAPACITY));
	assign match   = head_word.valid && (head_word.data == key_q) && !flag_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdll_pkg::S_IDLE: begin
				if (accept) state_d = bdll_pkg::S_RUN;
			end
			bdll_pkg::S_RUN: begin
				if (finish) state_d = bdll_pkg::S_IDLE;
			end
			default: state_d = bdll_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		shift    = 1'b0;
		case (state_q)
			bdll_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			bdll_pkg::S_RUN: begin
				// hold the last step while the previous result is still waiting
				shift = !last || !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// stream rewrite at the head of the ring
	always_comb begin
		fill    = head_word;
		carry_d = carry_q;
		flag_d  = flag_q;
		pos_d   = pos_q;
		case (op_q)
			bdll_pkg::OP_INS_FRONT: begin
				if (!refused) begin
					fill.valid = 1'b1;
					fill.data  = (step_q == '0) ? key_q : carry_q.data;
					fill.valid = (step_q == '0) ? 1'b1 : carry_q.valid;
					carry_d    = head_word;
				end
			end
			bdll_pkg::OP_INS_BACK: begin
				if (!refused && !flag_q && !head_word.valid) begin
					fill.valid = 1'b1;
					fill.data  = key_q;
					flag_d     = 1'b1;
				end
			end
			bdll_pkg::OP_DELETE: begin
				// after the drop every later entry moves up by one place
				if (flag_q || match) begin
					fill = next_word;
					if (last) fill.valid = 1'b0;
				end
				if (match) flag_d = 1'b1;
			end
			bdll_pkg::OP_SEARCH: begin
				if (match) begin
					flag_d = 1'b1;
					pos_d  = bdll_pkg::POS_W'(step_q) + bdll_pkg::POS_W'(1);
				end
			end
			default: begin
				fill = head_word;
			end
		endcase
	end

	// result and new fill level at the end of the turn
	always_comb begin
		fin_status = bdll_pkg::STAT_OK;
		fin_pos    = '0;
		fin_count  = count_q;
		case (op_q)
			bdll_pkg::OP_INS_FRONT, bdll_pkg::OP_INS_BACK: begin
				if (refused) fin_status = bdll_pkg::STAT_FULL;
				else         fin_count  = count_q + bdll_pkg::CNT_W'(1);
			end
			bdll_pkg::OP_DELETE: begin
				if (count_q == '0)   fin_status = bdll_pkg::STAT_EMPTY;
				else if (!flag_d)    fin_status = bdll_pkg::STAT_NOT_FOUND;
				else                 fin_count  = count_q - bdll_pkg::CNT_W'(1);
			end
			bdll_pkg::OP_SEARCH: begin
				if (flag_d) fin_pos    = pos_d;
				else        fin_status = bdll_pkg::STAT_NOT_FOUND;
			end
			default: begin
				fin_status = bdll_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdll_pkg::S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
				flag_q <= 1'b0;
			end else if (shift) begin
				step_q <= step_q + bdll_pkg::IDX_W'(1);
				flag_q <= flag_d;
			end
			if (finish) begin
				count_q     <= fin_count;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bdll_pkg::op_t'(op);
			key_q <= value;
			pos_q <= '0;
		end else if (shift) begin
			pos_q <= pos_d;
		end
		if (shift) begin
			carry_q <= carry_d;
		end
		if (finish) begin
			status_q   <= fin_status;
			position_q <= fin_pos;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign position        = position_q;
	assign chain_ctl.shift = shift;
	assign chain_ctl.fill  = fill;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bdll_pkg::CNT_W'(bdll_pkg::CAPACITY))
		else $error("fill level above capacity");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == bdll_pkg::S_RUN) && (step_q == '0))
		else $error("accepted word did not start a turn at step zero");

	a_pos_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (position_q != '0)) |-> (status_q == bdll_pkg::STAT_OK))
		else $error("nonzero position without a match");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bdll_pkg::S_IDLE) && !head_word.valid) |-> (count_q == '0))
		else $error("head cell empty while list holds entries");
`endif

endmodule

`default_nettype wire

FILE: hdl/bounded_doubly_linked_list.sv
// bounded_doubly_linked_list: top level, a ring of list cells and its sequencer.
// Depends on bdll_pkg, bdll_cell and bdll_ctrl.
//
// usage
// - input channel: in_valid / in_stall with op and value; one word is one operation
//   (insert at front, insert at back, delete first match, search)
// - output channel: out_valid / out_stall with status and position; exactly one
//   word per operation, in order
// - the list is kept in order in a ring of CAPACITY cells, head in the first cell;
//   every operation turns the ring once, one cell per cycle while out_stall does
//   not hold the last step, and the sequencer rewrites the word leaving the head
//   cell (insert, drop and close up, or match) and registers the result at turn end
// - in_stall is high for the whole turn, so one operation is in work at a time
// - a finished result waits in the output register; the next word may be accepted
//   meanwhile, and its turn holds at the last step while out_stall keeps the
//   earlier result in place
// - reset clears every cell's valid bit at once: the list starts empty, all
//   CAPACITY places free, no result pending; no clearing pass is needed
`default_nettype none

module bounded_doubly_linked_list (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [bdll_pkg::OP_W-1:0]          op,
	input  wire  [bdll_pkg::DATA_WIDTH-1:0]    value,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [bdll_pkg::STAT_W-1:0]        status,
	output logic [bdll_pkg::POS_W-1:0]         position
);

	// ring of cells, index 0 holds the list head when idle
	bdll_pkg::cell_word_t chain [bdll_pkg::CAPACITY];
	bdll_pkg::chain_ctl_t chain_ctl;

	bdll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.position  (position),
		.head_word (chain[0]),
		.next_word (chain[1]),
		.chain_ctl (chain_ctl)
	);

	// each cell takes its neighbor's word; the last one takes the rewritten head word
	for (genvar i = 0; i < bdll_pkg::CAPACITY; i++) begin : g_cell
		if (i == bdll_pkg::CAPACITY - 1) begin : g_tail
			bdll_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (chain_ctl.shift),
				.d      (chain_ctl.fill),
				.q      (chain[i])
			);
		end else begin : g_body
			bdll_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (chain_ctl.shift),
				.d      (chain[i+1]),
				.q      (chain[i])
			);
		end
	end

endmodule

`default_nettype wire
